@@ sv/cdi_pkg.sv @@
// Package for the coning delta-angle integrator: widths, codes, sequencer
// states and the control word of the shared multiplier pipe.
// No dependencies.
`timescale 1ns / 1ps

package cdi_pkg;

  localparam int RATE_W   = 32;
  localparam int ANG_W    = 48;
  localparam int TIME_W   = 32;
  localparam int PER_W    = 24;
  localparam int IVL_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam int C_W      = ANG_W + 1;
  localparam int MA_W     = 34;
  localparam int MB_W     = 26;
  localparam int MP_W     = MA_W + MB_W;
  localparam int ACC_W    = 100;
  localparam int PIECE_W  = 25;

  localparam int DIV_BITS = 8;
  localparam int CNT_W    = 5;
  localparam int DIV_CYC   = ANG_W / DIV_BITS;
  localparam int DELTA_CYC = 4;
  localparam int CROSS_CYC = 24;
  localparam int DRAIN_CYC = 2;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_PUBLISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT     = 1'b1;

  localparam logic [PER_W-1:0]  SAMPLE_PERIOD_RST = 24'd33554;
  localparam logic [TIME_W-1:0] GAP_LIMIT_RST     = 32'd100000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIXTH,
    ST_DELTA,
    ST_CROSS,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic       vld;
    logic       dlt;
    logic       sub;
    logic [1:0] sh;
    logic       first;
    logic       last;
    logic [1:0] axis;
  } ctl_t;

endpackage

@@ sv/cdi_if.sv @@
// Valid/ready channel interfaces for gyro items and published results.
// Depends on nothing.
`timescale 1ns / 1ps

interface cdi_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  logic        [31:0] sample_time_us;

  modport source (output valid, kind, rate_x, rate_y, rate_z, sample_time_us,
                  input ready);
  modport sink   (input valid, kind, rate_x, rate_y, rate_z, sample_time_us,
                  output ready);
endinterface

interface cdi_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] angle_x;
  logic signed [47:0] angle_y;
  logic signed [47:0] angle_z;
  logic        [31:0] interval;
  logic               fresh;

  modport source (output valid, angle_x, angle_y, angle_z, interval, fresh,
                  input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, interval, fresh,
                  output ready);
endinterface

@@ sv/coning_delta_angle_integrator.sv @@
// Top level: gyro delta-angle integrator with coning correction.
// Uses cdi_pkg and the channel interfaces in cdi_if.sv.
//
//  channel  | dir | transfer carries
//  ---------+-----+----------------------------------------------------
//  in_ch    | in  | kind, rate_x/y/z (Q16.16), sample_time_us
//  out_ch   | out | angle_x/y/z (2^-32 rad), interval (2^-28 s), fresh
//  cfg_*    | in  | register writes: sample_period, gap_limit_us
//
// A gyro sample occupies the block through the divide-by-six (8 bits a cycle),
// the three delta products, the coning partial products through the one 34x26
// multiplier, a drain of the multiplier pipe and a commit.
// A publish transfer needs a free output register.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps

module coning_delta_angle_integrator (
  input  logic                          clk,
  input  logic                          rst_n,
  cdi_in_if.sink                        in_ch,
  cdi_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cdi_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cdi_pkg::CFG_W-1:0]     cfg_data
);

  cdi_pkg::state_t state_r, state_nxt;
  logic [cdi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [cdi_pkg::PER_W-1:0]  period_r;
  logic [cdi_pkg::TIME_W-1:0] gap_lim_r;

  logic signed [cdi_pkg::ANG_W-1:0]  asum_r   [3];
  logic        [cdi_pkg::IVL_W-1:0]  isum_r;
  logic signed [cdi_pkg::ANG_W-1:0]  pdelta_r [3];
  logic signed [cdi_pkg::RATE_W-1:0] prate_r  [3];
  logic        [cdi_pkg::TIME_W-1:0] ptime_r;
  logic                              pending_r;

  logic signed [cdi_pkg::RATE_W-1:0] rate_r [3];
  logic signed [cdi_pkg::RATE_W-1:0] rate_in [3];
  logic        [cdi_pkg::TIME_W-1:0] now_r;
  logic                              gap_r;

  logic [cdi_pkg::ANG_W-1:0] dvd_r [3];
  logic [cdi_pkg::ANG_W-1:0] dvd_nxt [3];
  logic [2:0]                rem_r [3];
  logic [2:0]                rem_nxt [3];
  logic                      neg_r [3];

  logic signed [cdi_pkg::C_W-1:0]   c_r     [3];
  logic signed [cdi_pkg::ANG_W-1:0] delta_r [3];
  logic signed [cdi_pkg::ANG_W-1:0] cone_r  [3];

  logic signed [cdi_pkg::MA_W-1:0]  ma;
  logic signed [cdi_pkg::MB_W-1:0]  mb;
  logic signed [cdi_pkg::MP_W-1:0]  prod;
  logic signed [cdi_pkg::MP_W-1:0]  mul_r;
  cdi_pkg::ctl_t                    ctl_r, ctl_nxt;
  logic signed [cdi_pkg::ACC_W-1:0] acc_r;
  logic signed [cdi_pkg::ACC_W-1:0] term;
  logic                             fin_r;
  logic [1:0]                       fin_ax_r;
  logic signed [cdi_pkg::ANG_W-1:0] cone_sat;

  logic signed [cdi_pkg::ANG_W-1:0] oang_r [3];
  logic        [cdi_pkg::IVL_W-1:0] oivl_r;
  logic                             ofresh_r;
  logic                             ovalid_r;

  logic in_ready, in_fire, sample_fire, pub_fire, issue;

  assign rate_in[0] = in_ch.rate_x;
  assign rate_in[1] = in_ch.rate_y;
  assign rate_in[2] = in_ch.rate_z;

  assign in_ready    = (state_r == cdi_pkg::ST_IDLE) &&
                       (in_ch.kind == cdi_pkg::KIND_SAMPLE || !ovalid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign sample_fire = in_fire && (in_ch.kind == cdi_pkg::KIND_SAMPLE);
  assign pub_fire    = in_fire && (in_ch.kind == cdi_pkg::KIND_PUBLISH);

  assign out_ch.valid    = ovalid_r;
  assign out_ch.angle_x  = oang_r[0];
  assign out_ch.angle_y  = oang_r[1];
  assign out_ch.angle_z  = oang_r[2];
  assign out_ch.interval = oivl_r;
  assign out_ch.fresh    = ofresh_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdi_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    unique case (state_r)
      cdi_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (sample_fire) state_nxt = cdi_pkg::ST_SIXTH;
      end
      cdi_pkg::ST_SIXTH: begin
        if (cnt_r == cdi_pkg::CNT_W'(cdi_pkg::DIV_CYC - 1)) begin
          state_nxt = cdi_pkg::ST_DELTA;
          cnt_nxt   = '0;
        end
      end
      cdi_pkg::ST_DELTA: begin
        if (cnt_r == cdi_pkg::CNT_W'(cdi_pkg::DELTA_CYC - 1)) begin
          state_nxt = cdi_pkg::ST_CROSS;
          cnt_nxt   = '0;
        end
      end
      cdi_pkg::ST_CROSS: begin
        if (cnt_r == cdi_pkg::CNT_W'(cdi_pkg::CROSS_CYC - 1)) begin
          state_nxt = cdi_pkg::ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      cdi_pkg::ST_DRAIN: begin
        if (cnt_r == cdi_pkg::CNT_W'(cdi_pkg::DRAIN_CYC - 1)) begin
          state_nxt = cdi_pkg::ST_UPDATE;
          cnt_nxt   = '0;
        end
      end
      cdi_pkg::ST_UPDATE: begin
        state_nxt = cdi_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
      default: begin
        state_nxt = cdi_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= cdi_pkg::SAMPLE_PERIOD_RST;
      gap_lim_r <= cdi_pkg::GAP_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_idx == cdi_pkg::CFG_SAMPLE_PERIOD) period_r <= cfg_data[cdi_pkg::PER_W-1:0];
      else if (cfg_idx == cdi_pkg::CFG_GAP_LIMIT) gap_lim_r <= cfg_data[cdi_pkg::TIME_W-1:0];
    end
  end

  // divide-by-six, DIV_BITS restoring steps per cycle per lane
  always_comb begin
    logic [2:0]                r;
    logic [3:0]                t;
    logic [cdi_pkg::ANG_W-1:0] d;
    for (int i = 0; i < 3; i++) begin
      r = rem_r[i];
      d = dvd_r[i];
      for (int k = 0; k < cdi_pkg::DIV_BITS; k++) begin
        t = {r, d[cdi_pkg::ANG_W-1]};
        d = {d[cdi_pkg::ANG_W-2:0], 1'b0};
        if (t >= 4'd6) begin
          r    = 3'(t - 4'd6);
          d[0] = 1'b1;
        end else begin
          r = t[2:0];
        end
      end
      dvd_nxt[i] = d;
      rem_nxt[i] = r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (sample_fire) begin
        rate_r[i] <= rate_in[i];
        neg_r[i]  <= pdelta_r[i][cdi_pkg::ANG_W-1];
        dvd_r[i]  <= (pdelta_r[i][cdi_pkg::ANG_W-1] ? -pdelta_r[i] : pdelta_r[i])
                     + cdi_pkg::ANG_W'(3);
        rem_r[i]  <= '0;
      end else if (state_r == cdi_pkg::ST_SIXTH) begin
        dvd_r[i] <= dvd_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
      if (state_r == cdi_pkg::ST_DELTA && cnt_r == '0) begin
        c_r[i] <= {asum_r[i][cdi_pkg::ANG_W-1], asum_r[i]} +
                  (neg_r[i] ? -$signed({1'b0, dvd_r[i]}) : $signed({1'b0, dvd_r[i]}));
      end
    end
    if (sample_fire) begin
      now_r <= in_ch.sample_time_us;
      gap_r <= (in_ch.sample_time_us - ptime_r) > gap_lim_r;
    end
  end

  // multiplier operand select
  always_comb begin
    logic [1:0]                       ax, n1, n2, ci, di;
    logic [1:0]                       pc;
    logic                             p;
    logic signed [cdi_pkg::RATE_W:0]  rsum;
    logic signed [cdi_pkg::C_W-1:0]   cv;
    logic signed [cdi_pkg::ANG_W-1:0] dv;
    ax   = cnt_r[4:3];
    p    = cnt_r[2];
    pc   = cnt_r[1:0];
    unique case (ax)
      2'd0:    begin n1 = 2'd1; n2 = 2'd2; end
      2'd1:    begin n1 = 2'd2; n2 = 2'd0; end
      default: begin n1 = 2'd0; n2 = 2'd1; end
    endcase
    ci   = p ? n2 : n1;
    di   = p ? n1 : n2;
    cv   = c_r[ci];
    dv   = delta_r[di];
    rsum = {rate_r[pc][cdi_pkg::RATE_W-1], rate_r[pc]} +
           {prate_r[pc][cdi_pkg::RATE_W-1], prate_r[pc]};
    ctl_nxt = '0;
    if (state_r == cdi_pkg::ST_DELTA) begin
      issue = (cnt_r < cdi_pkg::CNT_W'(3));
      ma    = {rsum[cdi_pkg::RATE_W], rsum};
      mb    = {2'b00, period_r};
      ctl_nxt.vld  = issue;
      ctl_nxt.dlt  = 1'b1;
      ctl_nxt.axis = pc;
    end else begin
      issue = (state_r == cdi_pkg::ST_CROSS);
      ma    = pc[1] ? {{10{cv[cdi_pkg::C_W-1]}}, cv[cdi_pkg::C_W-1:cdi_pkg::PIECE_W]}
                    : {9'b0, cv[cdi_pkg::PIECE_W-1:0]};
      mb    = pc[0] ? {{3{dv[cdi_pkg::ANG_W-1]}}, dv[cdi_pkg::ANG_W-1:cdi_pkg::PIECE_W]}
                    : {1'b0, dv[cdi_pkg::PIECE_W-1:0]};
      ctl_nxt.vld   = issue;
      ctl_nxt.sub   = p;
      ctl_nxt.sh    = {1'b0, pc[1]} + {1'b0, pc[0]};
      ctl_nxt.first = (cnt_r[2:0] == 3'd0);
      ctl_nxt.last  = (cnt_r[2:0] == 3'd7);
      ctl_nxt.axis  = ax;
    end
    prod = ma * mb;
  end

  always_comb begin
    logic signed [cdi_pkg::ACC_W-1:0] tx;
    tx = {{(cdi_pkg::ACC_W - cdi_pkg::MP_W){mul_r[cdi_pkg::MP_W-1]}}, mul_r};
    case (ctl_r.sh)
      2'd0:    term = tx;
      2'd1:    term = tx <<< cdi_pkg::PIECE_W;
      default: term = tx <<< (2 * cdi_pkg::PIECE_W);
    endcase
  end

  // round by 2^-33 and saturate to 48 bits
  always_comb begin
    logic signed [cdi_pkg::ACC_W-1:0] rnd;
    rnd = (acc_r + (cdi_pkg::ACC_W'(1) <<< 32)) >>> 33;
    if (rnd[cdi_pkg::ACC_W-1:cdi_pkg::ANG_W-1] == '0 ||
        rnd[cdi_pkg::ACC_W-1:cdi_pkg::ANG_W-1] == '1) begin
      cone_sat = rnd[cdi_pkg::ANG_W-1:0];
    end else if (rnd[cdi_pkg::ACC_W-1]) begin
      cone_sat = {1'b1, {(cdi_pkg::ANG_W-1){1'b0}}};
    end else begin
      cone_sat = {1'b0, {(cdi_pkg::ANG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [cdi_pkg::ACC_W-1:0] base;
    if (!rst_n) begin
      ctl_r <= '0;
      fin_r <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
      fin_r <= ctl_r.vld && !ctl_r.dlt && ctl_r.last;
    end
    mul_r    <= prod;
    fin_ax_r <= ctl_r.axis;
    base     = ctl_r.first ? '0 : acc_r;
    if (ctl_r.vld) begin
      if (ctl_r.dlt) begin
        delta_r[ctl_r.axis] <= cdi_pkg::ANG_W'((mul_r + cdi_pkg::MP_W'(4096)) >>> 13);
      end else begin
        acc_r <= ctl_r.sub ? base - term : base + term;
      end
    end
    if (fin_r) cone_r[fin_ax_r] <= cone_sat;
  end

  // architectural state and result register
  always_ff @(posedge clk) begin
    logic signed [cdi_pkg::ANG_W+1:0] s;
    logic        [cdi_pkg::IVL_W:0]   iv;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        asum_r[i]   <= '0;
        pdelta_r[i] <= '0;
        prate_r[i]  <= '0;
      end
      isum_r    <= '0;
      ptime_r   <= '0;
      pending_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (pub_fire) begin
        for (int i = 0; i < 3; i++) begin
          oang_r[i] <= asum_r[i];
          asum_r[i] <= '0;
        end
        oivl_r    <= isum_r;
        ofresh_r  <= pending_r;
        isum_r    <= '0;
        pending_r <= 1'b0;
        ovalid_r  <= 1'b1;
      end else begin
        if (out_ch.ready) ovalid_r <= 1'b0;
        if (state_r == cdi_pkg::ST_UPDATE) begin
          for (int i = 0; i < 3; i++) begin
            s = (gap_r ? '0 : {{2{asum_r[i][cdi_pkg::ANG_W-1]}}, asum_r[i]}) +
                (gap_r ? '0 : {{2{delta_r[i][cdi_pkg::ANG_W-1]}}, delta_r[i]}) +
                {{2{cone_r[i][cdi_pkg::ANG_W-1]}}, cone_r[i]};
            if (s[cdi_pkg::ANG_W+1:cdi_pkg::ANG_W-1] == '0 ||
                s[cdi_pkg::ANG_W+1:cdi_pkg::ANG_W-1] == '1) begin
              asum_r[i] <= s[cdi_pkg::ANG_W-1:0];
            end else if (s[cdi_pkg::ANG_W+1]) begin
              asum_r[i] <= {1'b1, {(cdi_pkg::ANG_W-1){1'b0}}};
            end else begin
              asum_r[i] <= {1'b0, {(cdi_pkg::ANG_W-1){1'b1}}};
            end
            pdelta_r[i] <= gap_r ? '0 : delta_r[i];
            prate_r[i]  <= rate_r[i];
          end
          iv = {1'b0, isum_r} + cdi_pkg::IVL_W'(period_r);
          if (gap_r) isum_r <= '0;
          else       isum_r <= iv[cdi_pkg::IVL_W] ? '1 : iv[cdi_pkg::IVL_W-1:0];
          ptime_r   <= now_r;
          pending_r <= 1'b1;
        end
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == cdi_pkg::ST_IDLE)
    else $error("input ready outside idle");

  a_out_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(pub_fire))
    else $error("result raised without publish transfer");

  a_update_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdi_pkg::ST_UPDATE |-> $past(state_r) == cdi_pkg::ST_DRAIN)
    else $error("commit without drained multiplier pipe");

  a_pending_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdi_pkg::ST_UPDATE |=> pending_r)
    else $error("sample committed without setting pending");

  a_pipe_quiet_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cdi_pkg::ST_IDLE && $past(state_r) == cdi_pkg::ST_UPDATE |-> !ctl_r.vld)
    else $error("multiplier pipe busy after commit");

endmodule
